// ===== src/ppis_pkg.sv =====
package ppis_pkg;

    // field widths
    localparam int unsigned GainW    = 16;
    localparam int unsigned SampleW  = 16;
    localparam int unsigned ErrorW   = 17;
    localparam int unsigned DerivW   = 17;
    localparam int unsigned IntegW   = 24;
    localparam int unsigned BoundW   = 23;
    localparam int unsigned ThreshW  = 17;
    localparam int unsigned DriveW   = 32;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 23;

    // product and sum widths
    localparam int unsigned ProdPW = GainW + ErrorW;
    localparam int unsigned ProdIW = GainW + IntegW;
    localparam int unsigned ProdDW = GainW + DerivW;
    localparam int unsigned SumW   = ProdIW + 1;

    // default depth of the queue between front and back
    localparam int unsigned QueueDepthDef = 4;

    // register indexes
    localparam logic [CfgIdxW-1:0] RegGainP     = 3'd0;
    localparam logic [CfgIdxW-1:0] RegGainI     = 3'd1;
    localparam logic [CfgIdxW-1:0] RegGainD     = 3'd2;
    localparam logic [CfgIdxW-1:0] RegSetpoint  = 3'd3;
    localparam logic [CfgIdxW-1:0] RegIntBound  = 3'd4;
    localparam logic [CfgIdxW-1:0] RegSepThresh = 3'd5;

    localparam logic [ThreshW-1:0] SepThreshReset = 17'h1FFFF;

    // configuration as seen by the front and back
    typedef struct packed {
        logic signed [GainW-1:0]   gain_p;
        logic signed [GainW-1:0]   gain_i;
        logic signed [GainW-1:0]   gain_d;
        logic signed [SampleW-1:0] setpoint;
        logic [BoundW-1:0]         integral_bound;
        logic [ThreshW-1:0]        separation_threshold;
    } ppis_cfg_t;

    // one word handed from front to back
    typedef struct packed {
        logic signed [ErrorW-1:0] error;
        logic signed [IntegW-1:0] integ;
        logic signed [DerivW-1:0] deriv;
    } ppis_work_t;

endpackage

// ===== src/ppis_front.sv =====
module ppis_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ppis_pkg::ppis_cfg_t                  cfg,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [ppis_pkg::SampleW-1:0]  measured,
    input  logic signed [ppis_pkg::DerivW-1:0]   derivative,
    output logic                                 push,
    input  logic                                 push_ready,
    output ppis_pkg::ppis_work_t                 push_word
);
    import ppis_pkg::*;

    localparam int unsigned AccW = IntegW + 1;
    localparam int unsigned MagW = ErrorW + 1;

    logic signed [IntegW-1:0] integ_reg;
    logic signed [IntegW-1:0] integ_next;
    logic signed [ErrorW-1:0] prev_err_reg;

    logic signed [ErrorW-1:0] err;
    logic signed [AccW-1:0]   acc;
    logic signed [AccW-1:0]   bound_pos;
    logic signed [AccW-1:0]   bound_neg;
    logic signed [AccW-1:0]   clamped;
    logic signed [MagW-1:0]   err_wide;
    logic [MagW-1:0]          err_mag;
    logic                     separate;

    // word is taken whenever the queue has room
    assign in_ready = push_ready;
    assign push     = in_valid && push_ready;

    // error against the target
    assign err = ErrorW'({cfg.setpoint[SampleW-1], cfg.setpoint})
               - ErrorW'({measured[SampleW-1], measured});

    // previous error folded into the integral, then clamped
    assign acc       = AccW'(integ_reg) + AccW'(prev_err_reg);
    assign bound_pos = AccW'({1'b0, cfg.integral_bound});
    assign bound_neg = -bound_pos;

    always_comb
    begin
        if (acc > bound_pos)
        begin
            clamped = bound_pos;
        end
        else if (acc < bound_neg)
        begin
            clamped = bound_neg;
        end
        else
        begin
            clamped = acc;
        end
    end

    // integral separation on error magnitude
    assign err_wide = MagW'(err);
    assign err_mag  = err[ErrorW-1] ? MagW'(-err_wide) : MagW'(err_wide);
    assign separate = err_mag > {1'b0, cfg.separation_threshold};

    assign integ_next = separate ? '0 : clamped[IntegW-1:0];

    // word for the back end
    assign push_word.error = err;
    assign push_word.integ = integ_next;
    assign push_word.deriv = derivative;

    // loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg    <= '0;
            prev_err_reg <= '0;
        end
        else if (push)
        begin
            integ_reg    <= integ_next;
            prev_err_reg <= err;
        end
    end

endmodule

// ===== src/ppis_queue.sv =====
module ppis_queue #(
    parameter int unsigned DEPTH = ppis_pkg::QueueDepthDef
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 push_ready,
    input  ppis_pkg::ppis_work_t push_word,
    output logic                 pop_valid,
    input  logic                 pop,
    output ppis_pkg::ppis_work_t pop_word
);
    import ppis_pkg::*;

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    ppis_work_t          mem [DEPTH];
    logic [PtrW-1:0]     wr_ptr_reg;
    logic [PtrW-1:0]     rd_ptr_reg;
    logic [CntW-1:0]     count_reg;
    logic [CntW-1:0]     count_next;

    assign push_ready = count_reg != FullCnt;
    assign pop_valid  = count_reg != '0;
    assign pop_word   = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FullCnt)
        else $error("queue count above depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg != FullCnt)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("count did not follow push");

endmodule

// ===== src/ppis_back.sv =====
module ppis_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ppis_pkg::ppis_cfg_t                 cfg,
    input  logic                                pop_valid,
    output logic                                pop,
    input  ppis_pkg::ppis_work_t                pop_word,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [ppis_pkg::DriveW-1:0]  drive
);
    import ppis_pkg::*;

    localparam int unsigned ShW = SumW - 8;
    localparam logic signed [DriveW-1:0] DriveMax = {1'b0, {(DriveW-1){1'b1}}};
    localparam logic signed [DriveW-1:0] DriveMin = {1'b1, {(DriveW-1){1'b0}}};

    logic                     prod_vld_reg;
    logic signed [ProdPW-1:0] prod_p_reg;
    logic signed [ProdIW-1:0] prod_i_reg;
    logic signed [ProdDW-1:0] prod_d_reg;
    logic                     out_vld_reg;
    logic signed [DriveW-1:0] drive_reg;
    logic signed [DriveW-1:0] drive_next;

    logic                     out_take;
    logic                     prod_take;
    logic signed [SumW-1:0]   sum;
    logic signed [ShW-1:0]    sh;

    // stage enables: each stage moves when the one after it has room
    assign out_take  = !out_vld_reg || out_ready;
    assign prod_take = !prod_vld_reg || out_take;
    assign pop       = pop_valid && prod_take;

    // three products, registered
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            prod_p_reg <= pop_word.error * cfg.gain_p;
            prod_i_reg <= pop_word.integ * cfg.gain_i;
            prod_d_reg <= pop_word.deriv * cfg.gain_d;
        end
    end

    // sum, floor shift by 8, saturate
    assign sum = SumW'(prod_p_reg) + SumW'(prod_i_reg) + SumW'(prod_d_reg);
    assign sh  = sum[SumW-1:8];

    always_comb
    begin
        if (sh[ShW-1] && !sh[DriveW-1] && (sh[ShW-1:DriveW-1] != '1))
        begin
            drive_next = DriveMin;
        end
        else if (!sh[ShW-1] && (sh[ShW-1:DriveW-1] != '0))
        begin
            drive_next = DriveMax;
        end
        else
        begin
            drive_next = sh[DriveW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take && prod_vld_reg)
        begin
            drive_reg <= drive_next;
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (prod_take)
            begin
                prod_vld_reg <= pop;
            end
            if (out_take)
            begin
                out_vld_reg <= prod_vld_reg;
            end
        end
    end

    assign out_valid = out_vld_reg;
    assign drive     = drive_reg;

endmodule

// ===== src/positional_pid_integral_separation.sv =====
// channel   | valid / ready         | payload
// ----------+-----------------------+------------------------------
// input     | in_valid / in_ready   | measured (s16), derivative (s17)
// output    | out_valid / out_ready | drive (s32)
// config    | cfg_wen (no ready)    | cfg_index (3), cfg_wdata (23)
//
// one word per cycle sustained while out_ready stays high; the integral add and
// clamp in the front is combinational and is registered on each accepted word
// from input accept to out_valid a word passes the queue write at the accept
// edge, then the product registers, then the drive register after the sum
// reset clears loop state, queue and stage valids; registers take defaults
// the front stalls only when the queue (QUEUE_DEPTH words) is full, the back
// holds its two stages while out_ready is low
module positional_pid_integral_separation #(
    parameter int unsigned QUEUE_DEPTH = ppis_pkg::QueueDepthDef
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wen,
    input  logic [ppis_pkg::CfgIdxW-1:0]         cfg_index,
    input  logic [ppis_pkg::CfgDataW-1:0]        cfg_wdata,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [ppis_pkg::SampleW-1:0]  measured,
    input  logic signed [ppis_pkg::DerivW-1:0]   derivative,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [ppis_pkg::DriveW-1:0]   drive
);
    import ppis_pkg::*;

    ppis_cfg_t  cfg_reg;
    logic       push;
    logic       push_ready;
    ppis_work_t push_word;
    logic       pop;
    logic       pop_valid;
    ppis_work_t pop_word;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p               <= '0;
            cfg_reg.gain_i               <= '0;
            cfg_reg.gain_d               <= '0;
            cfg_reg.setpoint             <= '0;
            cfg_reg.integral_bound       <= '0;
            cfg_reg.separation_threshold <= SepThreshReset;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                RegGainP:     cfg_reg.gain_p               <= cfg_wdata[GainW-1:0];
                RegGainI:     cfg_reg.gain_i               <= cfg_wdata[GainW-1:0];
                RegGainD:     cfg_reg.gain_d               <= cfg_wdata[GainW-1:0];
                RegSetpoint:  cfg_reg.setpoint             <= cfg_wdata[SampleW-1:0];
                RegIntBound:  cfg_reg.integral_bound       <= cfg_wdata[BoundW-1:0];
                RegSepThresh: cfg_reg.separation_threshold <= cfg_wdata[ThreshW-1:0];
                default:      ;
            endcase
        end
    end

    // error and integral update
    ppis_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .measured   (measured),
        .derivative (derivative),
        .push       (push),
        .push_ready (push_ready),
        .push_word  (push_word)
    );

    // decoupling queue
    ppis_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .push_word  (push_word),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_word   (pop_word)
    );

    // gains, sum and saturation
    ppis_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_word  (pop_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .drive     (drive)
    );

endmodule

// ===== test/tb_positional_pid_integral_separation.sv =====
`timescale 1ns / 1ps

module tb_positional_pid_integral_separation;
    import ppis_pkg::*;

    // indexes with no register behind them
    localparam logic [CfgIdxW-1:0] RegUnusedLo = 3'd6;
    localparam logic [CfgIdxW-1:0] RegUnusedHi = 3'd7;

    localparam longint DriveMax = (longint'(1) <<< (DriveW - 1)) - 1;
    localparam longint DriveMin = -(longint'(1) <<< (DriveW - 1));
    localparam int HoldCycles = 300;
    localparam int PhaseWords = 220;

    typedef struct packed {
        logic signed [SampleW-1:0] measured;
        logic signed [DerivW-1:0]  derivative;
    } sample_word_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_wen;
    logic [CfgIdxW-1:0]        cfg_index;
    logic [CfgDataW-1:0]       cfg_wdata;
    logic                      in_valid;
    logic                      in_ready;
    logic signed [SampleW-1:0] measured;
    logic signed [DerivW-1:0]  derivative;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [DriveW-1:0]  drive;

    positional_pid_integral_separation dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .measured   (measured),
        .derivative (derivative),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .drive      (drive)
    );

    // controller settings and loop state as the testbench tracks them
    logic signed [GainW-1:0]   kp;
    logic signed [GainW-1:0]   ki;
    logic signed [GainW-1:0]   kd;
    logic signed [SampleW-1:0] target;
    logic [BoundW-1:0]         clamp_limit;
    logic [ThreshW-1:0]        sep_limit;
    logic signed [IntegW-1:0]  integ_sum;
    logic signed [ErrorW-1:0]  prev_err;

    sample_word_t              pending_words[$];
    logic signed [DriveW-1:0]  expected_drive[$];
    sample_word_t              next_word;
    logic signed [DriveW-1:0]  want_drive;
    int                        mismatches;
    bit                        no_idle;
    bit                        hold_request;
    int                        send_gap;
    int                        stall_left;
    int                        hold_left;
    int                        run_left;
    logic signed [SampleW-1:0] run_level;

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // one control step: update integral and error history, return the drive
    function automatic logic signed [DriveW-1:0] next_drive(sample_word_t w);
        longint err;
        longint acc;
        longint bound;
        longint total;
        err = longint'(target) - longint'($signed(w.measured));
        bound = longint'(clamp_limit);
        acc = longint'(integ_sum) + longint'(prev_err);
        if (acc > bound)
            acc = bound;
        else if (acc < -bound)
            acc = -bound;
        if (err > longint'(sep_limit) || err < -longint'(sep_limit))
            acc = 0;
        integ_sum = acc[IntegW-1:0];
        prev_err = err[ErrorW-1:0];
        total = longint'(kp) * err + longint'(ki) * acc
                + longint'(kd) * longint'($signed(w.derivative));
        total = total >>> 8;
        if (total > DriveMax)
            total = DriveMax;
        else if (total < DriveMin)
            total = DriveMin;
        return total[DriveW-1:0];
    endfunction

    // random sample: mostly steady runs around a level, some noise
    function automatic sample_word_t random_word();
        sample_word_t w;
        logic [31:0] rnd;
        int offs;
        if (run_left == 0)
        begin
            run_left = $urandom_range(5, 160);
            offs = $urandom_range(0, 4096) - 2048;
            rnd = $urandom;
            if ($urandom_range(0, 3) == 0)
                run_level = rnd[SampleW-1:0];
            else
                run_level = target + offs[SampleW-1:0];
        end
        run_left--;
        rnd = $urandom;
        offs = $urandom_range(0, 64) - 32;
        if ($urandom_range(0, 4) == 0)
            w.measured = rnd[SampleW-1:0];
        else
            w.measured = run_level + offs[SampleW-1:0];
        rnd = $urandom;
        offs = $urandom_range(0, 1024) - 512;
        if ($urandom_range(0, 1) == 0)
            w.derivative = offs[DerivW-1:0];
        else
            w.derivative = rnd[DerivW-1:0];
        return w;
    endfunction

    function automatic void push_word(int m, int d);
        sample_word_t w;
        w.measured = m[SampleW-1:0];
        w.derivative = d[DerivW-1:0];
        pending_words.push_back(w);
    endfunction

    // register write, mirrored into the tracked settings
    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            RegGainP:     kp = value[GainW-1:0];
            RegGainI:     ki = value[GainW-1:0];
            RegGainD:     kd = value[GainW-1:0];
            RegSetpoint:  target = value[SampleW-1:0];
            RegIntBound:  clamp_limit = value[BoundW-1:0];
            RegSepThresh: sep_limit = value[ThreshW-1:0];
            default:      ;
        endcase
    endtask

    // full register set, junk in unused upper bits and unused indexes
    task automatic apply_settings(int gp, int gi, int gd, int sp, int bnd, int thr);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(RegGainP, {junk[CfgDataW-1:GainW], gp[GainW-1:0]});
        write_reg(RegGainI, {junk[CfgDataW-1:GainW], gi[GainW-1:0]});
        write_reg(RegGainD, {junk[CfgDataW-1:GainW], gd[GainW-1:0]});
        write_reg(RegSetpoint, {junk[CfgDataW-1:SampleW], sp[SampleW-1:0]});
        write_reg(RegIntBound, bnd[BoundW-1:0]);
        write_reg(RegSepThresh, {junk[CfgDataW-1:ThreshW], thr[ThreshW-1:0]});
        write_reg(RegUnusedLo, junk[CfgDataW-1:0]);
        write_reg(RegUnusedHi, ~junk[CfgDataW-1:0]);
        @(posedge clk);
        cfg_wen <= 1'b0;
        @(negedge clk);
    endtask

    task automatic random_settings();
        int g[3];
        int sp;
        int bnd;
        int thr;
        foreach (g[k])
        begin
            case ($urandom_range(0, 4))
                0:       g[k] = -32768;
                1:       g[k] = 32767;
                2:       g[k] = 0;
                default: g[k] = $urandom;
            endcase
        end
        case ($urandom_range(0, 3))
            0:       sp = -32768;
            1:       sp = 32767;
            default: sp = $urandom;
        endcase
        case ($urandom_range(0, 3))
            0:       bnd = 0;
            1:       bnd = 8388607;
            2:       bnd = $urandom_range(0, 70000);
            default: bnd = $urandom_range(0, 8388607);
        endcase
        case ($urandom_range(0, 3))
            0:       thr = 0;
            1:       thr = 131071;
            2:       thr = $urandom_range(0, 4096);
            default: thr = $urandom_range(0, 131071);
        endcase
        apply_settings(g[0], g[1], g[2], sp, bnd, thr);
    endtask

    // block is idle once every word is sent and every result is back
    task automatic wait_drained();
        while (pending_words.size() != 0 || in_valid || expected_drive.size() != 0)
            @(negedge clk);
    endtask

    // input driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_drive.push_back(next_drive(sample_word_t'({measured, derivative})));
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    next_word = pending_words.pop_front();
                    measured   <= next_word.measured;
                    derivative <= next_word.derivative;
                    in_valid   <= 1'b1;
                    if (!no_idle && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 19);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // output monitor and receiver stalls
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_drive.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected drive word %0d", drive);
                    mismatches++;
                end
                else
                begin
                    want_drive = expected_drive.pop_front();
                    if (drive !== want_drive)
                    begin
                        if (mismatches < 10)
                            $display("drive mismatch: expected %0d, got %0d",
                                     want_drive, drive);
                        mismatches++;
                    end
                end
            end
            // long hold-off so the block backs up into its input
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HoldCycles;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // stimulus
    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wen = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        measured = '0;
        derivative = '0;
        out_ready = 1'b0;
        kp = '0;
        ki = '0;
        kd = '0;
        target = '0;
        clamp_limit = '0;
        sep_limit = SepThreshReset;
        integ_sum = '0;
        prev_err = '0;
        mismatches = 0;
        no_idle = 1'b0;
        hold_request = 1'b0;
        run_left = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: all gains zero
        push_word(-32768, -65536);
        push_word(32767, 65535);
        push_word(1234, -4321);
        push_word(-1, 1);
        wait_drained();

        // separation at the threshold and one above, small clamp
        apply_settings(32767, -32768, 1, 32767, 1000, 100);
        push_word(-32768, -65536);
        push_word(32767, 65535);
        push_word(32667, 0);
        push_word(32666, -1);
        push_word(32767, 0);
        push_word(32767, 0);
        push_word(32700, 12345);
        wait_drained();

        // widest error, negative integral growth at full bound
        apply_settings(-32768, 32767, -32768, -32768, 8388607, 131071);
        push_word(32767, 65535);
        push_word(32767, 65535);
        push_word(32767, 65535);
        push_word(-32768, -65536);
        push_word(0, 0);
        push_word(-1, -1);
        wait_drained();

        // floor rounding with unit gains, zero bound and zero threshold
        apply_settings(1, 1, 1, 0, 0, 0);
        push_word(0, -1);
        push_word(0, 255);
        push_word(0, -256);
        push_word(0, -257);
        push_word(1, 0);
        push_word(-1, 0);
        wait_drained();

        // random phases, extremes first, hold-off in one, no idling in the last
        for (int phase = 0; phase < 7; phase++)
        begin
            if (phase == 0)
                apply_settings(32767, 32767, 32767, 32767, 8388607, 131071);
            else if (phase == 1)
                apply_settings(-32768, -32768, -32768, -32768, 0, 0);
            else
                random_settings();
            if (phase == 3)
                hold_request = 1'b1;
            if (phase == 6)
                no_idle = 1'b1;
            repeat (PhaseWords) pending_words.push_back(random_word());
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_drive.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog
    initial
    begin
        #5000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== files.f =====
src/ppis_pkg.sv
src/ppis_front.sv
src/ppis_queue.sv
src/ppis_back.sv
src/positional_pid_integral_separation.sv
test/tb_positional_pid_integral_separation.sv
